@@ sv/sorted_alarm_timer_queue_top_assert.svh @@
// Assertion macros used by the timer queue top module
`ifndef SORTED_ALARM_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_ALARM_TIMER_QUEUE_TOP_ASSERT_SVH

// Check cons in the same cycle whenever ante holds
`define SATQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer queue check failed");

// Check cons in the cycle after ante holds
`define SATQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer queue check failed");

`endif

@@ sv/satq_pkg.sv @@
package satq_pkg;

   // Default queue depth
   localparam int DEPTH_DEFAULT = 16;

   // Wait reported for a pop from an empty queue
   localparam logic [31:0] EMPTY_WAIT = 32'd1;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_POPPED   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_ADD,
      S_INS_CMP,
      S_INS_LAST,
      S_POP_HEAD,
      S_POP_SHIFT
   } state_type;

   // One stored alarm
   typedef struct packed {
      logic [31:0] expiry;
      logic [15:0] tag;
      logic [15:0] delay;
   } entry_type;

endpackage

@@ sv/sorted_alarm_timer_queue_top.sv @@
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+--------------------------------
// request   | req_operation, req_now_seconds,        | taken when start && !busy
//           | req_delay_seconds, req_alarm_tag       |
// response  | rsp_status, rsp_out_tag, rsp_out_delay,| one cycle, marked by rsp_valid
//           | rsp_wait_seconds, rsp_entry_count      |
//
// Insert into a full queue and pop from an empty queue: response the cycle after accept.
// Insert: form the expiry, move later-or-equal entries up one, write the new one (directly if empty).
// Pop: read and report the head, then move each remaining entry down one; busy while the tail moves.
// The entry memory (one read, one write a cycle) and the shared add/compare unit set the pace.
// Reset is synchronous, active high; it empties the queue. Responses cannot be stalled.
`include "sorted_alarm_timer_queue_top_assert.svh"

module sorted_alarm_timer_queue_top #(
   parameter int DEPTH = satq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [31:0] req_now_seconds,
   input  logic [15:0] req_delay_seconds,
   input  logic [15:0] req_alarm_tag,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_tag,
   output logic [15:0] rsp_out_delay,
   output logic [31:0] rsp_wait_seconds,
   output logic [4:0]  rsp_entry_count
);

   localparam int AddrW = $clog2(DEPTH);
   localparam int CntW  = $clog2(DEPTH + 1);

   satq_pkg::state_type  state_ff, state_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [AddrW-1:0]     idx_ff, idx_in;
   logic [31:0]          now_ff, now_in;
   logic [31:0]          exp_ff, exp_in;
   logic [15:0]          delay_ff, delay_in;
   logic [15:0]          tag_ff, tag_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   satq_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [15:0]          rsp_tag_ff, rsp_tag_in;
   logic [15:0]          rsp_delay_ff, rsp_delay_in;
   logic [31:0]          rsp_wait_ff, rsp_wait_in;

   logic                 accept;
   logic                 is_full;
   logic                 is_empty;
   logic                 idx_at_last;
   logic [AddrW-1:0]     last_idx;
   logic [CntW+4:0]      count_ext;

   satq_pkg::alu_op_type alu_op;
   logic [31:0]          alu_a, alu_b, alu_result;
   logic                 alu_carry;

   logic                 wr_en;
   logic [AddrW-1:0]     wr_addr, rd_addr;
   satq_pkg::entry_type  wr_data, rd_data, new_entry;

   assign accept      = start && (state_ff == satq_pkg::S_IDLE);
   assign is_full     = (count_ff == CntW'(DEPTH));
   assign is_empty    = (count_ff == '0);
   assign last_idx    = AddrW'(count_ff - CntW'(1));
   assign idx_at_last = (CntW'(idx_ff) == count_ff);
   assign new_entry   = '{expiry: exp_ff, tag: tag_ff, delay: delay_ff};

   satq_alu u_alu (
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_result),
      .carry  (alu_carry)
   );

   satq_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         satq_pkg::S_IDLE: begin
            if (accept) begin
               if (req_operation == satq_pkg::OP_INSERT) begin
                  state_in = is_full ? satq_pkg::S_IDLE : satq_pkg::S_INS_ADD;
               end else begin
                  state_in = is_empty ? satq_pkg::S_IDLE : satq_pkg::S_POP_HEAD;
               end
            end
         end
         satq_pkg::S_INS_ADD: begin
            state_in = is_empty ? satq_pkg::S_IDLE : satq_pkg::S_INS_CMP;
         end
         satq_pkg::S_INS_CMP: begin
            if (!alu_carry) begin
               state_in = satq_pkg::S_IDLE;
            end else if (idx_ff == '0) begin
               state_in = satq_pkg::S_INS_LAST;
            end
         end
         satq_pkg::S_INS_LAST: begin
            state_in = satq_pkg::S_IDLE;
         end
         satq_pkg::S_POP_HEAD: begin
            state_in = (count_ff == CntW'(1)) ? satq_pkg::S_IDLE : satq_pkg::S_POP_SHIFT;
         end
         satq_pkg::S_POP_SHIFT: begin
            if (idx_at_last) begin
               state_in = satq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = satq_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath control, memory access and response
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      exp_in        = exp_ff;
      delay_in      = delay_ff;
      tag_in        = tag_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_delay_in  = rsp_delay_ff;
      rsp_wait_in   = rsp_wait_ff;
      alu_op        = satq_pkg::ALU_SUB;
      alu_a         = rd_data.expiry;
      alu_b         = exp_ff;
      wr_en         = 1'b0;
      wr_addr       = AddrW'(idx_ff + 1'b1);
      wr_data       = new_entry;
      rd_addr       = '0;
      unique case (state_ff)
         satq_pkg::S_IDLE: begin
            // Latch the request; answer full and empty cases at once
            if (accept) begin
               now_in   = req_now_seconds;
               delay_in = req_delay_seconds;
               tag_in   = req_alarm_tag;
               idx_in   = last_idx;
               if (req_operation == satq_pkg::OP_INSERT && is_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = satq_pkg::ST_FULL;
                  rsp_tag_in    = '0;
                  rsp_delay_in  = '0;
                  rsp_wait_in   = '0;
               end else if (req_operation == satq_pkg::OP_POP && is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = satq_pkg::ST_EMPTY;
                  rsp_tag_in    = '0;
                  rsp_delay_in  = '0;
                  rsp_wait_in   = satq_pkg::EMPTY_WAIT;
               end
            end
         end
         satq_pkg::S_INS_ADD: begin
            // Form the expiry; write directly into an empty queue
            alu_op  = satq_pkg::ALU_ADD;
            alu_a   = now_ff;
            alu_b   = {16'd0, delay_ff};
            exp_in  = alu_result;
            rd_addr = idx_ff;
            if (is_empty) begin
               wr_en         = 1'b1;
               wr_addr       = '0;
               wr_data       = '{expiry: alu_result, tag: tag_ff, delay: delay_ff};
               count_in      = count_ff + CntW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = satq_pkg::ST_INSERTED;
               rsp_tag_in    = '0;
               rsp_delay_in  = '0;
               rsp_wait_in   = '0;
            end
         end
         satq_pkg::S_INS_CMP: begin
            // Move later-or-equal entries up one; drop the new one in the gap
            wr_en = 1'b1;
            if (alu_carry) begin
               wr_data = rd_data;
               rd_addr = AddrW'(idx_ff - 1'b1);
               idx_in  = AddrW'(idx_ff - 1'b1);
            end else begin
               count_in      = count_ff + CntW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = satq_pkg::ST_INSERTED;
               rsp_tag_in    = '0;
               rsp_delay_in  = '0;
               rsp_wait_in   = '0;
            end
         end
         satq_pkg::S_INS_LAST: begin
            // New alarm becomes the head
            wr_en         = 1'b1;
            wr_addr       = '0;
            count_in      = count_ff + CntW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = satq_pkg::ST_INSERTED;
            rsp_tag_in    = '0;
            rsp_delay_in  = '0;
            rsp_wait_in   = '0;
         end
         satq_pkg::S_POP_HEAD: begin
            // Report the head and its remaining wait, start moving the tail
            alu_b         = now_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = satq_pkg::ST_POPPED;
            rsp_tag_in    = rd_data.tag;
            rsp_delay_in  = rd_data.delay;
            rsp_wait_in   = alu_carry ? alu_result : '0;
            count_in      = count_ff - CntW'(1);
            rd_addr       = AddrW'(1);
            idx_in        = AddrW'(1);
         end
         satq_pkg::S_POP_SHIFT: begin
            // Move each remaining entry down one place
            wr_en   = 1'b1;
            wr_addr = AddrW'(idx_ff - 1'b1);
            wr_data = rd_data;
            rd_addr = AddrW'(idx_ff + 1'b1);
            idx_in  = AddrW'(idx_ff + 1'b1);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= satq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      exp_ff        <= exp_in;
      delay_ff      <= delay_in;
      tag_ff        <= tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_delay_ff  <= rsp_delay_in;
      rsp_wait_ff   <= rsp_wait_in;
   end

   assign count_ext        = {5'd0, count_ff};
   assign busy             = (state_ff != satq_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_delay    = rsp_delay_ff;
   assign rsp_wait_seconds = rsp_wait_ff;
   assign rsp_entry_count  = count_ext[4:0];

   `SATQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(DEPTH))
   `SATQ_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid)
   `SATQ_ASSERT_NOW(a_full_status, clock, reset,
                    rsp_valid && rsp_status_ff == satq_pkg::ST_FULL, is_full)
   `SATQ_ASSERT_NOW(a_empty_status, clock, reset,
                    rsp_valid && rsp_status_ff == satq_pkg::ST_EMPTY,
                    is_empty && rsp_wait_ff == satq_pkg::EMPTY_WAIT)

endmodule

@@ sv/satq_alu.sv @@
module satq_alu (
   input  satq_pkg::alu_op_type op,
   input  logic [31:0]          opa,
   input  logic [31:0]          opb,
   output logic [31:0]          result,
   output logic                 carry
);

   logic [31:0] opb_mod;
   logic [32:0] full_sum;

   // Add, or subtract as a plus inverted b plus one; on a subtract, carry set means a >= b
   always_comb begin
      opb_mod  = (op == satq_pkg::ALU_SUB) ? ~opb : opb;
      full_sum = {1'b0, opa} + {1'b0, opb_mod} + {32'd0, (op == satq_pkg::ALU_SUB)};
   end

   assign result = full_sum[31:0];
   assign carry  = full_sum[32];

endmodule

@@ sv/satq_store.sv @@
module satq_store #(
   parameter int DEPTH = satq_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  satq_pkg::entry_type         wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output satq_pkg::entry_type         rd_data
);

   satq_pkg::entry_type mem [DEPTH];
   satq_pkg::entry_type rd_data_ff;

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, one address per cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/sv/tb.sv @@
module tb;
   import satq_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int DRAIN_WAIT  = DEPTH + 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      op_type      op;
      logic [31:0] now;
      logic [15:0] dly;
      logic [15:0] tag;
      int unsigned gap;
   } alarm_req_t;

   typedef struct {
      status_type  status;
      logic [15:0] tag;
      logic [15:0] dly;
      logic [31:0] wait_s;
      logic [4:0]  count;
   } alarm_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = 1'b0;
   logic [31:0] req_now_seconds = '0;
   logic [15:0] req_delay_seconds = '0;
   logic [15:0] req_alarm_tag = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_tag;
   logic [15:0] rsp_out_delay;
   logic [31:0] rsp_wait_seconds;
   logic [4:0]  rsp_entry_count;

   // Pending requests, expected responses and the predicted queue contents
   alarm_req_t  alarm_requests[$];
   alarm_rsp_t  due_responses[$];
   alarm_req_t  cur_req;
   logic [31:0] model_expiry[DEPTH];
   logic [15:0] model_tag[DEPTH];
   logic [15:0] model_dly[DEPTH];
   int          model_count = 0;

   int total_requests = 0;
   int accepted = 0;
   int responses = 0;
   int mismatches = 0;
   int gap_cnt = 0;
   int cycles = 0;
   int n_insert = 0, n_pop = 0, n_full = 0, n_empty = 0, peak_count = 0;

   sorted_alarm_timer_queue_top #(.DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_now_seconds   (req_now_seconds),
      .req_delay_seconds (req_delay_seconds),
      .req_alarm_tag     (req_alarm_tag),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_delay     (rsp_out_delay),
      .rsp_wait_seconds  (rsp_wait_seconds),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the predicted queue by one request and return its response
   function automatic alarm_rsp_t predict_alarm_response(alarm_req_t rq);
      alarm_rsp_t  r;
      logic [31:0] expiry;
      int          pos;
      int          i;
      r.status = ST_INSERTED;
      r.tag    = '0;
      r.dly    = '0;
      r.wait_s = '0;
      if (rq.op == OP_INSERT) begin
         expiry = rq.now + {16'd0, rq.dly};
         if (model_count >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // first entry due at or after the new one; newest wins ties
            pos = model_count;
            for (i = model_count - 1; i >= 0; i--)
               if (model_expiry[i] >= expiry) pos = i;
            for (i = model_count; i > pos; i--) begin
               model_expiry[i] = model_expiry[i-1];
               model_tag[i]    = model_tag[i-1];
               model_dly[i]    = model_dly[i-1];
            end
            model_expiry[pos] = expiry;
            model_tag[pos]    = rq.tag;
            model_dly[pos]    = rq.dly;
            model_count++;
         end
      end else if (model_count == 0) begin
         r.status = ST_EMPTY;
         r.wait_s = EMPTY_WAIT;
      end else begin
         r.status = ST_POPPED;
         r.tag    = model_tag[0];
         r.dly    = model_dly[0];
         r.wait_s = (model_expiry[0] > rq.now) ? model_expiry[0] - rq.now : 32'd0;
         for (i = 1; i < model_count; i++) begin
            model_expiry[i-1] = model_expiry[i];
            model_tag[i-1]    = model_tag[i];
            model_dly[i-1]    = model_dly[i];
         end
         model_count--;
      end
      r.count = model_count[4:0];
      return r;
   endfunction

   task automatic queue_request(op_type op, logic [31:0] now, logic [15:0] dly,
                                logic [15:0] tag, int unsigned gap);
      alarm_req_t rq;
      rq.op  = op;
      rq.now = now;
      rq.dly = dly;
      rq.tag = tag;
      rq.gap = gap;
      alarm_requests.push_back(rq);
      total_requests++;
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH response %0d %s: got 0x%0h expected 0x%0h",
               responses, field, got, want);
      mismatches++;
   endtask

   // Drive requests: hold start until taken, then idle for the next gap
   always @(posedge clock) begin
      alarm_rsp_t r;
      if (reset) begin
         start   <= 1'b0;
         gap_cnt  = 0;
      end else begin
         if (start && !busy) begin
            r = predict_alarm_response(cur_req);
            due_responses.push_back(r);
            accepted++;
            case (r.status)
               ST_INSERTED: n_insert++;
               ST_POPPED:   n_pop++;
               ST_FULL:     n_full++;
               default:     n_empty++;
            endcase
            if (model_count > peak_count) peak_count = model_count;
         end
         if (!start || !busy) begin
            if (alarm_requests.size() != 0 && gap_cnt >= alarm_requests[0].gap) begin
               cur_req            = alarm_requests.pop_front();
               gap_cnt            = 0;
               start             <= 1'b1;
               req_operation     <= cur_req.op;
               req_now_seconds   <= cur_req.now;
               req_delay_seconds <= cur_req.dly;
               req_alarm_tag     <= cur_req.tag;
            end else begin
               start <= 1'b0;
               if (alarm_requests.size() != 0) gap_cnt++;
            end
         end
      end
   end

   // Check each response against the oldest expectation
   always @(posedge clock) begin
      alarm_rsp_t want;
      if (!reset && rsp_valid) begin
         if (due_responses.size() == 0) begin
            report_mismatch("unexpected response, status", {30'd0, rsp_status}, 32'd0);
         end else begin
            want = due_responses.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
            if (rsp_out_tag !== want.tag)
               report_mismatch("out_tag", {16'd0, rsp_out_tag}, {16'd0, want.tag});
            if (rsp_out_delay !== want.dly)
               report_mismatch("out_delay", {16'd0, rsp_out_delay}, {16'd0, want.dly});
            if (rsp_wait_seconds !== want.wait_s)
               report_mismatch("wait_seconds", rsp_wait_seconds, want.wait_s);
            if (rsp_entry_count !== want.count)
               report_mismatch("entry_count", {27'd0, rsp_entry_count}, {27'd0, want.count});
         end
         responses++;
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d requests taken",
                  cycles, accepted, total_requests);
         $display("sorted_alarm_timer_queue_top test failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] base;
      logic [31:0] now;
      logic [15:0] dly;
      op_type      op;
      int          ins_pct;
      bit          no_idle;
      int          blk;
      int          k;

      // Directed: empty pop, field extremes, wrap, ties, expired and equal waits
      queue_request(OP_POP,    32'h0000_0000, 16'h0000, 16'h0000, 0);
      queue_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0);
      queue_request(OP_INSERT, 32'h0000_0000, 16'h0000, 16'h0000, 3);
      queue_request(OP_INSERT, 32'h0000_0010, 16'h0000, 16'h1234, 0);
      queue_request(OP_INSERT, 32'h0000_0000, 16'h0010, 16'h5678, 1);
      queue_request(OP_POP,    32'h0000_0005, 16'hFFFF, 16'hFFFF, 0);
      queue_request(OP_POP,    32'h0000_0010, 16'h0000, 16'h0000, 2);
      queue_request(OP_POP,    32'h0000_0000, 16'h0000, 16'h0000, 0);
      queue_request(OP_POP,    32'h0000_0000, 16'h0000, 16'h0000, 0);
      // fill the queue, then push one more into the full queue
      for (k = 0; k <= DEPTH; k++)
         queue_request(OP_INSERT, 32'h8000_0000 + k, 16'(DEPTH - k), 16'(k), k % 3);

      // Random blocks with varying insert mix, time jumps near wrap and idle patterns
      base = $urandom();
      for (blk = 0; blk < 17; blk++) begin
         case ($urandom_range(0, 3))
            0:       ins_pct = 25;
            1:       ins_pct = 50;
            2:       ins_pct = 75;
            default: ins_pct = 90;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) base = $urandom();
         if ($urandom_range(0, 4) == 0) base = 32'hFFFF_FFFF - $urandom_range(0, 70000);
         for (k = 0; k < 100; k++) begin
            base = base + $urandom_range(0, 4);
            now  = ($urandom_range(0, 19) == 0) ? $urandom() : base;
            case ($urandom_range(0, 3))
               0:       dly = 16'($urandom_range(0, 3));
               1:       dly = 16'hFFFF - 16'($urandom_range(0, 3));
               default: dly = 16'($urandom());
            endcase
            op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP;
            queue_request(op, now, dly, 16'($urandom()),
                          no_idle ? 0 : $urandom_range(0, 8));
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything taken and answered, then allow a late stray response
      @(negedge clock);
      while (accepted < total_requests || due_responses.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (due_responses.size() != 0)
         report_mismatch("responses never seen, count", due_responses.size(), 0);
      $display("ran %0d requests in %0d cycles: %0d inserts, %0d pops, %0d full drops,",
               accepted, cycles, n_insert, n_pop, n_full);
      $display("%0d empty pops, peak occupancy %0d; %0d mismatches",
               n_empty, peak_count, mismatches);
      if (mismatches == 0) begin
         $display("sorted_alarm_timer_queue_top test passed");
      end else begin
         $display("sorted_alarm_timer_queue_top test failed");
      end
      $finish;
   end

endmodule
